// ===== src/valid_sample_history_average_top_defines.svh =====
// assertion macros used by the checker file
`ifndef VALID_SAMPLE_HISTORY_AVERAGE_TOP_DEFINES_SVH
`define VALID_SAMPLE_HISTORY_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication
`define VSHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VSHA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/vsha_pkg.sv =====
package vsha_pkg;

   // fixed field widths
   localparam int TEMP_W    = 12;
   localparam int COUNT_W   = 4;
   localparam int CSR_IDX_W = 2;

   // saturation value of the reported count
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_LOW  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_HIGH = CSR_IDX_W'(1);

   // limit reset values, 1/16 degree units (-40 C and 60 C)
   localparam logic signed [TEMP_W-1:0] VALID_LOW_RST  = -12'sd640;
   localparam logic signed [TEMP_W-1:0] VALID_HIGH_RST = 12'sd960;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic scan;
      logic prep;
      logic divide;
      logic publish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

// ===== src/vsha_req_if.sv =====
interface vsha_req_if import vsha_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// ===== src/vsha_rsp_if.sv =====
interface vsha_rsp_if import vsha_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] average;
   logic [COUNT_W-1:0]       valid_count;
   logic                     no_valid;

   modport source (output valid, output average, output valid_count, output no_valid,
                   input ready);
   modport sink (input valid, input average, input valid_count, input no_valid,
                 output ready);
endinterface

// ===== src/vsha_csr_if.sv =====
interface vsha_csr_if import vsha_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TEMP_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/vsha_ram.sv =====
module vsha_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/vsha_ctrl.sv =====
module vsha_ctrl import vsha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.divide = 1'b1;
         end
         ST_FINISH: begin
            cmd.publish = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== src/vsha_dpath.sv =====
module vsha_dpath import vsha_pkg::*; #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [TEMP_W-1:0] sample,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [TEMP_W-1:0]        csr_data,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [TEMP_W-1:0] average,
   output logic [COUNT_W-1:0]       valid_count,
   output logic                     no_valid
);

   localparam int AW      = $clog2(HISTORY_DEPTH);
   localparam int CW      = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W   = TEMP_W + AW;
   localparam int DIV_W   = SUM_W + (SUM_W % 2);
   localparam int DIV_CYC = DIV_W / 2;
   localparam int DCW     = $clog2(DIV_CYC);
   localparam int RW      = CW + 1;
   localparam int CX      = (CW > COUNT_W) ? CW : COUNT_W;

   localparam logic [AW-1:0]  LAST_ADDR = AW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0]  DEPTH_CNT = CW'(HISTORY_DEPTH);
   localparam logic [DCW-1:0] DIV_LAST  = DCW'(DIV_CYC - 1);

   logic signed [TEMP_W-1:0] low_ff, low_in, high_ff, high_in;
   logic [AW-1:0]            wptr_ff, wptr_in;
   logic [CW-1:0]            fill_ff, fill_in;
   logic [CW-1:0]            scan_ff, scan_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [AW-1:0]            rd_addr_ff, rd_addr_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic [DIV_W-1:0]         dq_ff, dq_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic [DCW-1:0]           dcnt_ff, dcnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] avg_ff, avg_in;
   logic [COUNT_W-1:0]       vcnt_ff, vcnt_in;
   logic                     nov_ff, nov_in;

   logic                     rd_en;
   logic [TEMP_W-1:0]        ram_rd_data;
   logic signed [TEMP_W-1:0] hist;
   logic                     take;
   logic [SUM_W-1:0]         mag;
   logic [RW-1:0]            divisor;
   logic [RW-1:0]            r0, r1;
   logic                     q0, q1;
   logic [DIV_W-1:0]         d0;
   logic [DIV_W-1:0]         quot;
   logic [CX-1:0]            cnt_ext;

   // history store, written as a circular buffer
   vsha_ram #(
      .WIDTH(TEMP_W),
      .DEPTH(HISTORY_DEPTH)
   ) u_hist (
      .clock  (clock),
      .wr_en  (cmd.accept),
      .wr_addr(wptr_ff),
      .wr_data(sample),
      .rd_en  (rd_en),
      .rd_addr(scan_ff[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   // limit registers
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VALID_LOW:  low_in  = csr_data;
            CSR_VALID_HIGH: high_in = csr_data;
            default: begin
               low_in  = low_ff;
               high_in = high_ff;
            end
         endcase
      end
   end

   // write pointer and fill count; unwritten slots never count
   always_comb begin
      wptr_in = wptr_ff;
      fill_in = fill_ff;
      if (cmd.accept) begin
         wptr_in = (wptr_ff == LAST_ADDR) ? '0 : wptr_ff + AW'(1);
         if (fill_ff != DEPTH_CNT) fill_in = fill_ff + CW'(1);
      end
   end

   // scan of the history, one entry per cycle
   assign rd_en      = cmd.scan && (scan_ff < DEPTH_CNT);
   assign rd_vld_in  = rd_en;
   assign rd_addr_in = scan_ff[AW-1:0];
   assign hist       = ram_rd_data;
   assign take       = rd_vld_ff && (CW'(rd_addr_ff) < fill_ff) && (hist != '0) &&
                       (hist > low_ff) && (hist < high_ff);

   always_comb begin
      scan_in = scan_ff;
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      if (cmd.accept) begin
         scan_in = '0;
         sum_in  = '0;
         cnt_in  = '0;
      end else begin
         if (rd_en) scan_in = scan_ff + CW'(1);
         if (take) begin
            sum_in = sum_ff + {{(SUM_W-TEMP_W){hist[TEMP_W-1]}}, hist};
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   // divider: magnitude of the sum over the count, two quotient bits a cycle
   assign mag     = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign divisor = RW'(cnt_ff);

   always_comb begin
      r0 = {rem_ff[RW-2:0], dq_ff[DIV_W-1]};
      q0 = (r0 >= divisor);
      if (q0) r0 = r0 - divisor;
      d0 = {dq_ff[DIV_W-2:0], q0};
      r1 = {r0[RW-2:0], d0[DIV_W-1]};
      q1 = (r1 >= divisor);
      if (q1) r1 = r1 - divisor;
   end

   always_comb begin
      neg_in  = neg_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dcnt_in = dcnt_ff;
      if (cmd.prep) begin
         neg_in  = sum_ff[SUM_W-1];
         dq_in   = DIV_W'(mag);
         rem_in  = '0;
         dcnt_in = '0;
      end else if (cmd.divide) begin
         dq_in   = {d0[DIV_W-2:0], q1};
         rem_in  = r1;
         dcnt_in = dcnt_ff + DCW'(1);
      end
   end

   // result formatting
   assign quot    = neg_ff ? (~dq_ff + DIV_W'(1)) : dq_ff;
   assign cnt_ext = CX'(cnt_ff);

   always_comb begin
      avg_in       = avg_ff;
      vcnt_in      = vcnt_ff;
      nov_in       = nov_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         nov_in       = (cnt_ff == '0);
         avg_in       = (cnt_ff == '0) ? '0 : quot[TEMP_W-1:0];
         vcnt_in      = (cnt_ext > CX'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[COUNT_W-1:0];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= VALID_LOW_RST;
         high_ff      <= VALID_HIGH_RST;
         wptr_ff      <= '0;
         fill_ff      <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         wptr_ff      <= wptr_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      neg_ff     <= neg_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      avg_ff     <= avg_in;
      vcnt_ff    <= vcnt_in;
      nov_ff     <= nov_in;
   end

   // status back to the controller
   assign status.scan_done = (scan_ff == DEPTH_CNT);
   assign status.div_done  = (dcnt_ff == DIV_LAST);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign average     = avg_ff;
   assign valid_count = vcnt_ff;
   assign no_valid    = nov_ff;

endmodule

// ===== src/valid_sample_history_average_top.sv =====
// Moving average of the most recent temperature samples with a range gate.
// req_chan takes one signed sample (1/16 degree C) per request; rsp_chan returns
// one result per request: the mean of the valid stored samples truncated
// toward zero, the number of valid samples and a flag for none valid.
// csr_chan writes the exclusive lower (index 0) and upper (index 1) limits;
// it is always ready and other indexes are ignored.
// A request passes through the scan, prep, divide and finish states; the divider
// works on DIV_W bits, 12 + ceil(log2(HISTORY_DEPTH)) rounded up to even.
// The history sits in a RAM read one entry per cycle, and the divider
// retires two quotient bits per cycle; one request is in work at a time, so a
// new request is taken only once the last one has been published.
// Reset empties the history (no clearing pass needed) and loads -40 C and
// 60 C as limits. A result waits in an output register while the receiver
// stalls; the next request still runs and holds before publishing until the
// output register frees.
module valid_sample_history_average_top import vsha_pkg::*; #(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   vsha_req_if.sink   req_chan,
   vsha_rsp_if.source rsp_chan,
   vsha_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type status;

   // sequencing of one request
   vsha_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   // history, accumulation, divider and output register
   vsha_dpath #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .sample     (req_chan.sample),
      .csr_we     (csr_chan.valid),
      .csr_index  (csr_chan.index),
      .csr_data   (csr_chan.data),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .average    (rsp_chan.average),
      .valid_count(rsp_chan.valid_count),
      .no_valid   (rsp_chan.no_valid)
   );

   // limit writes are taken at once
   assign csr_chan.ready = 1'b1;

endmodule

// ===== src/vsha_checker.sv =====
`include "valid_sample_history_average_top_defines.svh"

module vsha_checker import vsha_pkg::*; #(
   parameter int HISTORY_DEPTH = 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] average,
   input logic [COUNT_W-1:0]       valid_count,
   input logic                     no_valid
);

   localparam int CNT_LIMIT = (HISTORY_DEPTH > 15) ? 15 : HISTORY_DEPTH;

   // flag agrees with the count
   `VSHA_ASSERT_IMP(a_flag_count, clock, reset, rsp_valid, no_valid == (valid_count == '0), "no_valid disagrees with valid_count")

   // no valid sample gives a zero mean
   `VSHA_ASSERT_IMP(a_zero_avg, clock, reset, rsp_valid && no_valid, average == '0, "average nonzero with no valid sample")

   // count never exceeds the history
   `VSHA_ASSERT_IMP(a_count_max, clock, reset, rsp_valid, valid_count <= COUNT_W'(CNT_LIMIT), "valid_count above history depth")

   // one request in work at a time
   `VSHA_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // stalled result holds
   `VSHA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(average), "stalled result changed")

endmodule

bind valid_sample_history_average_top vsha_checker #(
   .HISTORY_DEPTH(HISTORY_DEPTH)
) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .average    (rsp_chan.average),
   .valid_count(rsp_chan.valid_count),
   .no_valid   (rsp_chan.no_valid)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import vsha_pkg::*;

   localparam int HIST_DEPTH  = 8;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASE_ITEMS = 100;
   localparam int PHASES      = 14;
   localparam int PRINT_LIMIT = 30;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = CSR_IDX_W'(3);

   typedef logic signed [TEMP_W-1:0] temp_type;

   typedef struct packed {
      temp_type           average;
      logic [COUNT_W-1:0] valid_count;
      logic               no_valid;
   } avg_result_type;

   logic clock;
   logic reset;

   vsha_req_if req_if ();
   vsha_rsp_if rsp_if ();
   vsha_csr_if csr_if ();

   valid_sample_history_average_top #(
      .HISTORY_DEPTH(HIST_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // shadow of the block state
   temp_type       sample_history [HIST_DEPTH];
   temp_type       limit_low;
   temp_type       limit_high;
   avg_result_type pending_averages [$];

   // idling controls shared with the driver processes
   int unsigned req_gap_max;
   int unsigned rsp_gap_max;
   int unsigned rsp_hold_cycles;

   // run statistics
   int unsigned mismatch_count;
   int unsigned requests_sent;
   int unsigned results_checked;
   int unsigned empty_results;
   int unsigned full_results;
   int unsigned limit_settings;
   int unsigned input_stall_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // reset and idle inputs
   initial begin
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.sample <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
   endtask

   // mean of the in-range nonzero history entries
   function automatic avg_result_type predict_average();
      int             total;
      int             hits;
      avg_result_type r;
      total = 0;
      hits  = 0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         if (sample_history[i] != 0 && sample_history[i] > limit_low &&
             sample_history[i] < limit_high) begin
            total += int'(sample_history[i]);
            hits++;
         end
      end
      r.average     = (hits > 0) ? TEMP_W'(total / hits) : '0;
      r.valid_count = (hits > 15) ? COUNT_MAX : COUNT_W'(hits);
      r.no_valid    = (hits == 0);
      return r;
   endfunction

   // shift the accepted sample in and queue its result
   function automatic void record_sample(input temp_type value);
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
         sample_history[i] = sample_history[i - 1];
      end
      sample_history[0] = value;
      pending_averages.push_back(predict_average());
      requests_sent++;
   endfunction

   function automatic temp_type clamp_temp(input int v);
      if (v < -2048) return -12'sd2048;
      if (v > 2047) return 12'sd2047;
      return TEMP_W'(v);
   endfunction

   // one request; valid stays high when the next one follows at once
   task automatic send_sample(input temp_type value);
      int unsigned gap;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= value;
      do @(posedge clock); while (!req_if.ready);
      record_sample(value);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_VALID_LOW) begin
         limit_low = data;
      end else if (idx == CSR_VALID_HIGH) begin
         limit_high = data;
      end
   endtask

   task automatic write_limits(input temp_type lo, input temp_type hi);
      write_reg(CSR_VALID_LOW, lo);
      write_reg(CSR_VALID_HIGH, hi);
      csr_if.valid <= 1'b0;
      limit_settings++;
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_drain();
      req_if.valid <= 1'b0;
      wait (pending_averages.size() == 0);
   endtask

   // random sample biased toward the limits and the valid window
   function automatic temp_type draw_sample();
      int lo;
      int hi;
      lo = int'(limit_low);
      hi = int'(limit_high);
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2: return TEMP_W'($urandom);
         3: return clamp_temp(lo + $urandom_range(0, 2) - 1);
         4: return clamp_temp(hi + $urandom_range(0, 2) - 1);
         default: begin
            if (hi - lo >= 2) return TEMP_W'(lo + 1 + $urandom_range(0, hi - lo - 2));
            return TEMP_W'($urandom);
         end
      endcase
   endfunction

   // response ready with random stalls and requested hold-offs
   initial begin : rsp_drive
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            while (rsp_hold_cycles > 0) begin
               @(posedge clock);
               rsp_hold_cycles--;
            end
         end
         stall = (rsp_gap_max > 0) ? $urandom_range(0, rsp_gap_max) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid && rsp_hold_cycles == 0);
      end
   end

   // compare each result with the oldest expected one
   initial begin : result_check
      avg_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && req_if.valid && !req_if.ready) begin
            input_stall_cycles++;
         end
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (pending_averages.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = pending_averages.pop_front();
               if (rsp_if.average !== want.average) begin
                  report_mismatch($sformatf("average %0d, want %0d",
                                            rsp_if.average, want.average));
               end
               if (rsp_if.valid_count !== want.valid_count) begin
                  report_mismatch($sformatf("valid_count %0d, want %0d",
                                            rsp_if.valid_count, want.valid_count));
               end
               if (rsp_if.no_valid !== want.no_valid) begin
                  report_mismatch($sformatf("no_valid %0b, want %0b",
                                            rsp_if.no_valid, want.no_valid));
               end
               if (want.no_valid) empty_results++;
               if (want.valid_count == COUNT_W'(HIST_DEPTH)) full_results++;
            end
         end
      end
   end

   // samples right at and beside the reset limits, zero and the field extremes
   task automatic test_reset_limits();
      temp_type vals [10] = '{-12'sd640, -12'sd639, 12'sd959, 12'sd960, 12'sd0,
                              -12'sd2048, 12'sd2047, 12'sd1, -12'sd1, 12'sd100};
      req_gap_max = 2;
      rsp_gap_max = 2;
      foreach (vals[i]) send_sample(vals[i]);
      wait_drain();
   endtask

   // widest window, full history, negative mean truncated toward zero
   task automatic test_wide_limits();
      write_limits(-12'sd2048, 12'sd2047);
      send_sample(-12'sd2048);
      send_sample(12'sd2047);
      repeat (6) send_sample(-12'sd2047);
      repeat (2) send_sample(12'sd2046);
      wait_drain();
   endtask

   // equal and crossed limits let nothing through
   task automatic test_crossed_limits();
      write_limits(12'sd100, 12'sd100);
      send_sample(12'sd100);
      send_sample(12'sd50);
      wait_drain();
      write_limits(12'sd500, -12'sd500);
      send_sample(12'sd0);
      wait_drain();
      write_limits(12'sd2047, -12'sd2048);
      send_sample(12'sd7);
      wait_drain();
   endtask

   // writes to unmapped indexes leave the limits alone
   task automatic test_unmapped_index();
      write_limits(-12'sd10, 12'sd10);
      write_reg(CSR_UNMAPPED_A, 12'h000);
      write_reg(CSR_UNMAPPED_B, 12'h7ff);
      csr_if.valid <= 1'b0;
      send_sample(12'sd5);
      wait_drain();
   endtask

   // random samples over a range of limit settings and idling mixes
   task automatic test_random_phases();
      int unsigned gap_choice [3] = '{0, 3, 18};
      int          lo;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 5)
            0: write_limits(-12'sd2048, 12'sd2047);
            1: write_limits(TEMP_W'(-int'($urandom_range(0, 2048))),
                            TEMP_W'($urandom_range(0, 2047)));
            2: begin
               lo = int'($urandom_range(0, 4088)) - 2048;
               write_limits(TEMP_W'(lo), TEMP_W'(lo + $urandom_range(1, 6)));
            end
            3: write_limits(TEMP_W'($urandom), TEMP_W'($urandom));
            default: write_limits(VALID_LOW_RST, VALID_HIGH_RST);
         endcase
         req_gap_max = gap_choice[ph % 3];
         rsp_gap_max = gap_choice[(ph / 3) % 3];
         repeat (PHASE_ITEMS) send_sample(draw_sample());
         wait_drain();
      end
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      write_limits(-12'sd800, 12'sd800);
      req_gap_max     = 0;
      rsp_gap_max     = 0;
      rsp_hold_cycles = 300;
      repeat (24) send_sample(draw_sample());
      wait_drain();
      rsp_gap_max = 4;
   endtask

   // test sequence
   initial begin
      limit_low       = VALID_LOW_RST;
      limit_high      = VALID_HIGH_RST;
      foreach (sample_history[i]) sample_history[i] = '0;
      req_gap_max     = 0;
      rsp_gap_max     = 0;
      rsp_hold_cycles = 0;
      @(posedge clock iff !reset);

      test_reset_limits();
      test_wide_limits();
      test_crossed_limits();
      test_unmapped_index();
      test_random_phases();
      test_backpressure();

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d results over %0d limit settings",
               requests_sent, results_checked, limit_settings);
      $display("%0d results had nothing in range, %0d a full history; input stalled %0d cycles",
               empty_results, full_results, input_stall_cycles);
      if (mismatch_count == 0 && pending_averages.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", pending_averages.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/vsha_pkg.sv
src/vsha_req_if.sv
src/vsha_rsp_if.sv
src/vsha_csr_if.sv
src/vsha_ram.sv
src/vsha_ctrl.sv
src/vsha_dpath.sv
src/valid_sample_history_average_top.sv
src/vsha_checker.sv
tb/tb_top.sv
